// ----- rtl/indexed_array_insert_remove_search_unit_defines.svh -----
// assertion macros for the indexed array unit
`ifndef INDEXED_ARRAY_INSERT_REMOVE_SEARCH_UNIT_DEFINES_SVH
`define INDEXED_ARRAY_INSERT_REMOVE_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define IAIRS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("indexed array check failed");

// next-cycle implication
`define IAIRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("indexed array check failed");

`endif

// ----- rtl/iairs_pkg.sv -----
// shared constants, types and helpers for the indexed array unit
`default_nettype none

package iairs_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W   = 3;
  localparam int POS_W  = 6;
  localparam int WORD_W = 32;
  localparam int NLEN_W = 6;
  localparam int STAT_W = 2;
  localparam int MPOS_W = 5;
  localparam int MTOT_W = 6;
  localparam int CLEN_W = 6;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd4;
  localparam logic [OP_W-1:0] OP_RESIZE = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_LENGTH = 2'd3;

  typedef logic [1:0] emit_kind_t;
  localparam emit_kind_t EM_PLAIN = 2'd0;
  localparam emit_kind_t EM_READ  = 2'd1;
  localparam emit_kind_t EM_MATCH = 2'd2;
  localparam emit_kind_t EM_LAST  = 2'd3;

  typedef struct packed {
    logic [3:0]        pad;
    logic [NLEN_W-1:0] new_length;
    logic [WORD_W-1:0] data_word;
    logic [POS_W-1:0]  position;
  } in_data_t;

  typedef struct packed {
    logic [3:0]        pad;
    logic [CLEN_W-1:0] current_length;
    logic [MTOT_W-1:0] match_total;
    logic              match_valid;
    logic [MPOS_W-1:0] match_position;
    logic [WORD_W-1:0] read_word;
    logic [STAT_W-1:0] status;
  } out_data_t;

  typedef struct packed {
    logic              load;
    logic              set_status;
    logic [STAT_W-1:0] status_code;
    logic              rd_pos;
    logic              wr_pos;
    logic              scan_init;
    logic              scan_step;
    logic              consume;
    logic              fill_inc;
    logic              fill_dec;
    logic              fill_clear;
    logic              fill_resize;
    logic              emit;
    emit_kind_t        emit_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pos_lt_fill;
    logic            pos_le_fill;
    logic            full;
    logic            nlen_ok;
    logic            remain_zero;
    logic            rvalid;
    logic            match;
    logic            pend_valid;
    logic            out_free;
  } dp_stat_t;

  function automatic logic [5:0] sat6(input logic [CNT_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'd63) begin
      return 6'd63;
    end
    return 6'(v);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/iairs_dp.sv -----
// datapath: element memory, length, scan counter, match tracking, output register
`default_nettype none

module iairs_dp
  import iairs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  input  wire logic [OP_W-1:0]        s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic                        m_tlast,
  input  wire dp_cmd_t                cmd,
  output dp_stat_t                    stat
);

  logic [WORD_W-1:0] mem [CAPACITY];

  in_data_t          in_d;
  logic [OP_W-1:0]   op_q;
  logic [POS_W-1:0]  pos_q;
  logic [WORD_W-1:0] word_q;
  logic [NLEN_W-1:0] nlen_q;
  logic [STAT_W-1:0] status_q;

  logic [CNT_W-1:0]  fill;
  logic [ADDR_W-1:0] scan_addr;
  logic [CNT_W-1:0]  remain;
  logic              rvalid;
  logic [ADDR_W-1:0] ridx;
  logic [WORD_W-1:0] rdata;
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_pos;
  logic [CNT_W-1:0]  total;

  out_data_t         out_q;
  logic              out_last;
  out_data_t         out_next;
  logic              last_next;

  logic [CMP_W-1:0]  pos_w;
  logic [CMP_W-1:0]  fill_w;
  logic [CMP_W-1:0]  nlen_w;
  logic [CMP_W-1:0]  cap_w;

  logic [ADDR_W-1:0] init_addr;
  logic [CNT_W-1:0]  init_remain;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              is_shift;
  logic              match;

  assign in_d   = in_data_t'(s_tdata);
  assign pos_w  = CMP_W'(pos_q);
  assign fill_w = CMP_W'(fill);
  assign nlen_w = CMP_W'(nlen_q);
  assign cap_w  = CMP_W'(CAPACITY);
  assign match  = (rdata == word_q);

  assign is_shift = (op_q == OP_INSERT) || (op_q == OP_REMOVE);

  // start point and length of the walk for each operation
  always_comb begin
    init_addr   = '0;
    init_remain = '0;
    case (op_q)
      OP_INSERT: begin
        init_addr   = ADDR_W'(fill_w - CMP_W'(1));
        init_remain = CNT_W'(fill_w - pos_w);
      end
      OP_REMOVE: begin
        init_addr   = ADDR_W'(pos_w + CMP_W'(1));
        init_remain = CNT_W'(fill_w - pos_w - CMP_W'(1));
      end
      OP_FIND: begin
        init_remain = fill;
      end
      OP_RESIZE: begin
        init_addr = ADDR_W'(fill_w);
        if (nlen_w > fill_w) begin
          init_remain = CNT_W'(nlen_w - fill_w);
        end
      end
      default: begin
        init_remain = '0;
      end
    endcase
  end

  // one read and one write port
  always_comb begin
    rd_en   = cmd.rd_pos || (cmd.scan_step && (op_q != OP_RESIZE));
    rd_addr = cmd.rd_pos ? ADDR_W'(pos_q) : scan_addr;

    wr_en   = 1'b0;
    wr_addr = ADDR_W'(pos_q);
    wr_data = word_q;
    if (cmd.wr_pos) begin
      wr_en = 1'b1;
    end else if (cmd.scan_step && (op_q == OP_RESIZE)) begin
      wr_en   = 1'b1;
      wr_addr = scan_addr;
      wr_data = '0;
    end else if (cmd.consume && is_shift) begin
      wr_en   = 1'b1;
      wr_data = rdata;
      // insert moves entries up, remove moves them down
      wr_addr = (op_q == OP_INSERT) ? ridx + 1'b1 : ridx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
      ridx  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= s_tuser;
      pos_q  <= in_d.position;
      word_q <= in_d.data_word;
      nlen_q <= in_d.new_length;
    end
    if (cmd.scan_init) begin
      scan_addr <= init_addr;
      remain    <= init_remain;
    end else if (cmd.scan_step) begin
      scan_addr <= (op_q == OP_INSERT) ? scan_addr - 1'b1 : scan_addr + 1'b1;
      remain    <= remain - 1'b1;
    end
    if (cmd.consume && (op_q == OP_FIND) && match) begin
      pend_pos <= ridx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      rvalid     <= 1'b0;
      pend_valid <= 1'b0;
      total      <= '0;
      status_q   <= ST_OK;
    end else begin
      if (cmd.load) begin
        status_q <= ST_OK;
      end else if (cmd.set_status) begin
        status_q <= cmd.status_code;
      end

      if (cmd.fill_clear) begin
        fill <= '0;
      end else if (cmd.fill_resize) begin
        fill <= CNT_W'(nlen_w);
      end else if (cmd.fill_inc) begin
        fill <= fill + 1'b1;
      end else if (cmd.fill_dec) begin
        fill <= fill - 1'b1;
      end

      // a word left over from a read is dropped when the next item loads
      if (rd_en) begin
        rvalid <= 1'b1;
      end else if (cmd.consume || cmd.load) begin
        rvalid <= 1'b0;
      end

      if (cmd.scan_init) begin
        pend_valid <= 1'b0;
        total      <= '0;
      end else if (cmd.consume && (op_q == OP_FIND) && match) begin
        pend_valid <= 1'b1;
        total      <= total + 1'b1;
      end
    end
  end

  // output register, loads whenever the controller emits
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    out_next                = '0;
    out_next.status         = status_q;
    out_next.current_length = sat6(fill);
    last_next               = 1'b1;
    case (cmd.emit_kind)
      EM_READ: begin
        if (status_q == ST_OK) begin
          out_next.read_word = rdata;
        end
      end
      EM_MATCH: begin
        out_next.match_position = MPOS_W'(pend_pos);
        out_next.match_valid    = 1'b1;
        last_next               = 1'b0;
      end
      EM_LAST: begin
        if (pend_valid) begin
          out_next.match_position = MPOS_W'(pend_pos);
        end
        out_next.match_valid = pend_valid;
        out_next.match_total = sat6(total);
      end
      default: begin
        last_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_q    <= out_next;
      out_last <= last_next;
    end
  end

  assign m_tdata = OUT_TDATA_W'(out_q);
  assign m_tlast = out_last;

  always_comb begin
    stat.op          = op_q;
    stat.pos_lt_fill = pos_w < fill_w;
    stat.pos_le_fill = pos_w <= fill_w;
    stat.full        = fill_w == cap_w;
    stat.nlen_ok     = nlen_w <= cap_w;
    stat.remain_zero = (remain == '0);
    stat.rvalid      = rvalid;
    stat.match       = match;
    stat.pend_valid  = pend_valid;
    stat.out_free    = !m_tvalid || m_tready;
  end

endmodule

`default_nettype wire

// ----- rtl/iairs_ctrl.sv -----
// controller state machine sequencing each operation over the datapath
`default_nettype none

module iairs_ctrl
  import iairs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FIND   = 3'd3;
  localparam logic [2:0] S_FEND   = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       find_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  // a match waits only if it would push out a pending one into a busy output
  assign find_take = stat.rvalid && (!stat.match || !stat.pend_valid || stat.out_free);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        state_next = S_EMIT;
        unique case (stat.op)
          OP_READ: begin
            if (stat.pos_lt_fill) begin
              cmd.rd_pos = 1'b1;
            end else begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end
          end
          OP_WRITE: begin
            if (stat.pos_lt_fill) begin
              cmd.wr_pos = 1'b1;
            end else begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end
          end
          OP_INSERT: begin
            if (!stat.pos_le_fill) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end else if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          OP_REMOVE: begin
            if (!stat.pos_lt_fill) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          OP_FIND: begin
            cmd.scan_init = 1'b1;
            state_next    = S_FIND;
          end
          OP_RESIZE: begin
            if (!stat.nlen_ok) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_LENGTH;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          OP_CLEAR: begin
            cmd.fill_clear = 1'b1;
          end
          default: begin
            state_next = S_EMIT;
          end
        endcase
      end

      // shift entries or zero-fill growth, one entry per cycle
      S_SCAN: begin
        cmd.scan_step = !stat.remain_zero;
        cmd.consume   = stat.rvalid;
        if (stat.remain_zero && !stat.rvalid) begin
          state_next = S_EMIT;
          unique case (stat.op)
            OP_INSERT: begin
              cmd.wr_pos   = 1'b1;
              cmd.fill_inc = 1'b1;
            end
            OP_REMOVE: begin
              cmd.fill_dec = 1'b1;
            end
            OP_RESIZE: begin
              cmd.fill_resize = 1'b1;
            end
            default: begin
              state_next = S_EMIT;
            end
          endcase
        end
      end

      S_FIND: begin
        cmd.consume   = find_take;
        cmd.scan_step = !stat.remain_zero && (!stat.rvalid || find_take);
        if (find_take && stat.match && stat.pend_valid) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_MATCH;
        end
        if (stat.remain_zero && !stat.rvalid) begin
          state_next = S_FEND;
        end
      end

      S_FEND: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_LAST;
          state_next    = S_IDLE;
        end
      end

      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = (stat.op == OP_READ) ? EM_READ : EM_PLAIN;
          state_next    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/indexed_array_insert_remove_search_unit.sv -----
// top level of the indexed array unit with insert, remove and search
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid / tready    tuser opcode, tdata position, data_word, new_length
//   m_*      out  tvalid / tready    tdata status .. current_length, tlast last_result
//
// read, write, clear and rejected items pass from accept through decode straight to emit
// insert shifts the entries from position to the end up, remove shifts those above it down
// find scans every entry up to the length; resize zero-fills any growth
// any output stall holds an operation; memory has one read and one write port
// synchronous reset empties the array at once; the next item is taken while a result waits
`default_nettype none
`include "indexed_array_insert_remove_search_unit_defines.svh"

module indexed_array_insert_remove_search_unit
  import iairs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // position[5:0], data_word[37:6], new_length[43:38], zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // opcode[2:0]
  input  wire logic [OP_W-1:0]        s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // status[1:0], read_word[33:2], match_position[38:34], match_valid[39],
  // match_total[45:40], current_length[51:46], zero pad
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic                        m_tlast
);

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_data_t out_view;

  iairs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  iairs_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

  assign out_view = out_data_t'(m_tdata);

  `IAIRS_ASSERT_SAME(a_emit_into_free, cmd.emit, stat.out_free)
  `IAIRS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `IAIRS_ASSERT_SAME(a_mid_find_is_match, m_tvalid && !m_tlast, out_view.match_valid)
  `IAIRS_ASSERT_SAME(a_length_bound, m_tvalid, 7'(out_view.current_length) <= 7'(CAPACITY))

endmodule

`default_nettype wire

// ----- dv/indexed_array_insert_remove_search_unit_tb.sv -----
// self-checking testbench for the indexed array unit: directed table, then random items
`timescale 1ns / 1ps

module indexed_array_insert_remove_search_unit_tb;
  import iairs_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] read_word;
    logic [MPOS_W-1:0] match_position;
    logic              match_valid;
    logic [MTOT_W-1:0] match_total;
    logic              last;
    logic [CLEN_W-1:0] length;
  } array_result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    logic [NLEN_W-1:0] nlen;
    logic              typed;
    logic [STAT_W-1:0] t_status;
    logic [WORD_W-1:0] t_word;
    logic [CLEN_W-1:0] t_length;
  } stimulus_row_t;

  // every row goes through the array predictor; rows with typed = 1 then set their own status, word and length
  localparam int NUM_ROWS = 26;
  localparam stimulus_row_t STIMULUS_TABLE [NUM_ROWS] = '{
    '{OP_READ,   6'd0,  32'h0,        6'd0,  1'b1, ST_RANGE,  32'h0, 6'd0},
    '{OP_FIND,   6'd0,  32'h0,        6'd0,  1'b0, ST_OK,     32'h0, 6'd0},
    '{OP_REMOVE, 6'd0,  32'h0,        6'd0,  1'b1, ST_RANGE,  32'h0, 6'd0},
    '{OP_INSERT, 6'd1,  32'h5,        6'd0,  1'b1, ST_RANGE,  32'h0, 6'd0},
    '{OP_RESIZE, 6'd0,  32'h0,        6'd33, 1'b1, ST_LENGTH, 32'h0, 6'd0},
    '{OP_RESIZE, 6'd0,  32'h0,        6'd63, 1'b1, ST_LENGTH, 32'h0, 6'd0},
    '{OP_RESIZE, 6'd0,  32'h0,        6'd32, 1'b1, ST_OK,     32'h0, 6'd32},
    '{OP_INSERT, 6'd0,  32'h1,        6'd0,  1'b1, ST_FULL,   32'h0, 6'd32},
    '{OP_INSERT, 6'd33, 32'h1,        6'd0,  1'b1, ST_RANGE,  32'h0, 6'd32},
    '{OP_READ,   6'd31, 32'h0,        6'd0,  1'b1, ST_OK,     32'h0, 6'd32},
    '{OP_READ,   6'd32, 32'h0,        6'd0,  1'b1, ST_RANGE,  32'h0, 6'd32},
    '{OP_WRITE,  6'd31, 32'h7fffffff, 6'd0,  1'b0, ST_OK,     32'h0, 6'd0},
    '{OP_WRITE,  6'd0,  32'h80000000, 6'd0,  1'b0, ST_OK,     32'h0, 6'd0},
    '{OP_FIND,   6'd0,  32'h0,        6'd0,  1'b0, ST_OK,     32'h0, 6'd0},
    '{OP_FIND,   6'd0,  32'h80000000, 6'd0,  1'b0, ST_OK,     32'h0, 6'd0},
    '{OP_FIND,   6'd0,  32'h12345678, 6'd0,  1'b0, ST_OK,     32'h0, 6'd0},
    '{OP_REMOVE, 6'd31, 32'h0,        6'd0,  1'b0, ST_OK,     32'h0, 6'd0},
    '{OP_REMOVE, 6'd0,  32'h0,        6'd0,  1'b0, ST_OK,     32'h0, 6'd0},
    '{OP_INSERT, 6'd30, 32'hffffffff, 6'd0,  1'b0, ST_OK,     32'h0, 6'd0},
    '{OP_INSERT, 6'd0,  32'h55555555, 6'd0,  1'b0, ST_OK,     32'h0, 6'd0},
    '{OP_RESIZE, 6'd0,  32'h0,        6'd0,  1'b1, ST_OK,     32'h0, 6'd0},
    '{OP_RESIZE, 6'd0,  32'h0,        6'd3,  1'b0, ST_OK,     32'h0, 6'd0},
    '{OP_WRITE,  6'd2,  32'haaaaaaaa, 6'd0,  1'b0, ST_OK,     32'h0, 6'd0},
    '{OP_CLEAR,  6'd0,  32'h0,        6'd0,  1'b1, ST_OK,     32'h0, 6'd0},
    '{OP_RESIZE, 6'd0,  32'h0,        6'd2,  1'b0, ST_OK,     32'h0, 6'd0},
    '{OP_FIND,   6'd0,  32'h0,        6'd0,  1'b0, ST_OK,     32'h0, 6'd0}
  };

  localparam int RANDOM_PER_PHASE = 50;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [OP_W-1:0]        s_tuser  = OP_READ;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  logic [WORD_W-1:0] shadow_elements [CAPACITY];
  int                shadow_fill;
  array_result_t     expected_results [$];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_off       = 1'b0;
  int  mismatch_count = 0;
  int  items_sent     = 0;
  int  results_seen   = 0;
  int  find_matches   = 0;
  int  error_results  = 0;

  indexed_array_insert_remove_search_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  initial begin
    #4000000;
    $display("indexed_array_insert_remove_search_unit test failed");
    $finish;
  end

  always @(negedge clk) begin
    m_tready = !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // queues every result one array operation causes and updates the shadow array
  task automatic predict_array_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                  input logic [WORD_W-1:0] word,
                                  input logic [NLEN_W-1:0] nlen);
    array_result_t r;
    int            hits;
    int            i;
    r = '0;
    r.last = 1'b1;
    r.length = 6'(shadow_fill);
    hits = 0;
    case (op)
      OP_READ: begin
        if (pos >= shadow_fill) r.status = ST_RANGE;
        else r.read_word = shadow_elements[pos];
      end
      OP_WRITE: begin
        if (pos >= shadow_fill) r.status = ST_RANGE;
        else shadow_elements[pos] = word;
      end
      OP_INSERT: begin
        if (pos > shadow_fill) begin
          r.status = ST_RANGE;
        end else if (shadow_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_fill; i > pos; i--) shadow_elements[i] = shadow_elements[i-1];
          shadow_elements[pos] = word;
          shadow_fill++;
        end
      end
      OP_REMOVE: begin
        if (pos >= shadow_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (i = pos; i + 1 < shadow_fill; i++) shadow_elements[i] = shadow_elements[i+1];
          shadow_fill--;
          shadow_elements[shadow_fill] = '0;
        end
      end
      OP_FIND: begin
        // each match is held back one step so the final one can carry the total
        r.last = 1'b0;
        for (i = 0; i < shadow_fill; i++) begin
          if (shadow_elements[i] == word) begin
            if (hits != 0) expected_results.push_back(r);
            r.match_position = 5'(i);
            r.match_valid = 1'b1;
            hits++;
          end
        end
        r.last = 1'b1;
        r.match_total = 6'(hits);
      end
      OP_RESIZE: begin
        if (nlen > CAPACITY) begin
          r.status = ST_LENGTH;
        end else begin
          for (i = shadow_fill; i < nlen; i++) shadow_elements[i] = '0;
          shadow_fill = nlen;
        end
      end
      OP_CLEAR: shadow_fill = 0;
      default: ;
    endcase
    r.length = 6'(shadow_fill);
    expected_results.push_back(r);
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [WORD_W-1:0] word, input logic [NLEN_W-1:0] nlen,
                           input logic typed, input logic [STAT_W-1:0] t_status,
                           input logic [WORD_W-1:0] t_word,
                           input logic [CLEN_W-1:0] t_length);
    in_data_t      pkt;
    array_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    pkt = '0;
    pkt.position = pos;
    pkt.data_word = word;
    pkt.new_length = nlen;
    s_tdata = pkt;
    s_tuser = op;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_array_op(op, pos, word, nlen);
    if (typed) begin
      r = expected_results.pop_back();
      r.status = t_status;
      r.read_word = t_word;
      r.length = t_length;
      expected_results.push_back(r);
    end
    items_sent++;
  endtask

  // mostly valid indexes and half the words already stored, so finds hit and the array fills up
  task automatic send_random_item();
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    logic [NLEN_W-1:0] nlen;
    int                sel;
    sel = $urandom_range(99);
    if (sel < 15) op = OP_READ;
    else if (sel < 30) op = OP_WRITE;
    else if (sel < 52) op = OP_INSERT;
    else if (sel < 67) op = OP_REMOVE;
    else if (sel < 82) op = OP_FIND;
    else if (sel < 95) op = OP_RESIZE;
    else op = OP_CLEAR;
    if ($urandom_range(9) == 0) pos = 6'($urandom_range(32));
    else pos = 6'($urandom_range(shadow_fill));
    case ($urandom_range(3))
      0: word = $urandom();
      1: begin
        case ($urandom_range(5))
          0: word = 32'h0;
          1: word = 32'hffffffff;
          2: word = 32'h80000000;
          3: word = 32'h7fffffff;
          4: word = 32'h1;
          default: word = 32'h2;
        endcase
      end
      default: begin
        if (shadow_fill > 0) word = shadow_elements[$urandom_range(shadow_fill - 1)];
        else word = 32'h0;
      end
    endcase
    if ($urandom_range(19) == 0) nlen = 6'($urandom_range(63, 33));
    else nlen = 6'($urandom_range(32));
    send_item(op, pos, word, nlen, 1'b0, ST_OK, '0, '0);
  endtask

  // the sender drops valid first so the last item is not offered again
  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_data_t     got;
    array_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = out_data_t'(m_tdata);
      results_seen++;
      if (got.match_valid) find_matches++;
      if (got.status != ST_OK) error_results++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected", 64'(m_tdata), 64'h0);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.read_word !== want.read_word)
          report_mismatch("read_word", 64'(got.read_word), 64'(want.read_word));
        if (got.match_position !== want.match_position)
          report_mismatch("match_position", 64'(got.match_position),
                          64'(want.match_position));
        if (got.match_valid !== want.match_valid)
          report_mismatch("match_valid", 64'(got.match_valid), 64'(want.match_valid));
        if (got.match_total !== want.match_total)
          report_mismatch("match_total", 64'(got.match_total), 64'(want.match_total));
        if (m_tlast !== want.last)
          report_mismatch("last_result", 64'(m_tlast), 64'(want.last));
        if (got.current_length !== want.length)
          report_mismatch("current_length", 64'(got.current_length), 64'(want.length));
      end
    end
  end

  initial begin
    int ph;
    int k;
    for (k = 0; k < CAPACITY; k++) shadow_elements[k] = '0;
    shadow_fill = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (k = 0; k < NUM_ROWS; k++)
      send_item(STIMULUS_TABLE[k].op, STIMULUS_TABLE[k].pos, STIMULUS_TABLE[k].word,
                STIMULUS_TABLE[k].nlen, STIMULUS_TABLE[k].typed,
                STIMULUS_TABLE[k].t_status, STIMULUS_TABLE[k].t_word,
                STIMULUS_TABLE[k].t_length);
    wait_for_results();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (ph == 0) begin
        // long receiver hold-off while items keep coming, so the input backs up
        fork
          begin
            hold_off = 1'b1;
            repeat (150) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (k = 0; k < RANDOM_PER_PHASE; k++) send_random_item();
      // sender pauses until the pipeline is empty
      wait_for_results();
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    wait_for_results();
    repeat (40) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 64'(expected_results.size()), 64'h0);

    $display("covered %0d items and %0d results: %0d find matches, %0d error statuses",
             items_sent, results_seen, find_matches, error_results);
    $display("idle mixes: none, sender, receiver, both; one long receiver hold-off");
    if (mismatch_count == 0) begin
      $display("indexed_array_insert_remove_search_unit test passed");
    end else begin
      $display("indexed_array_insert_remove_search_unit test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/iairs_pkg.sv
rtl/iairs_dp.sv
rtl/iairs_ctrl.sv
rtl/indexed_array_insert_remove_search_unit.sv
dv/indexed_array_insert_remove_search_unit_tb.sv
